>>> hw/rtl/stfc_pkg.sv
// Package: type codes, shared structs and helpers for the sample converter
`default_nettype none
package stfc_pkg;
   localparam logic [15:0] Uint16Mask = 16'hFFFF;

   typedef enum logic [2:0] {
      IN_UINT8   = 3'd0,
      IN_UINT16  = 3'd1,
      IN_INT16   = 3'd2,
      IN_INT32   = 3'd3,
      IN_FLOAT32 = 3'd4,
      IN_FLOAT64 = 3'd5
   } in_code_type;

   typedef enum logic [1:0] {
      OUT_SAME    = 2'd0,
      OUT_FLOAT32 = 2'd1,
      OUT_INT32   = 2'd2
   } out_code_type;

   localparam logic CSR_INPUT_TYPE  = 1'b0;
   localparam logic CSR_OUTPUT_TYPE = 1'b1;

   typedef enum logic [2:0] {
      OP_BAD  = 3'b001,
      OP_PASS = 3'b010,
      OP_CONV = 3'b100
   } op_type;

   // Result of the first stage: what to do and the operands prepared for it.
   typedef struct packed {
      op_type      op;
      logic        last;
      logic [63:0] pass_val;   // masked pass-through word
      logic        is_dbl;     // conversion from double
      logic        neg;        // integer sign
      logic [31:0] mag;        // integer magnitude
   } s1_type;
endpackage
`default_nettype wire

>>> hw/rtl/sample_type_to_float32_converter.sv
// Top level: three-stage sample type to float32/int32 converter
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  req     | req_valid, req_stall, req_raw_value, req_last_in | in
//  rsp     | rsp_valid, rsp_stall, rsp_converted_value,       | out
//          | rsp_last_out, rsp_bad_pairing                   |
//  csr     | csr_write, csr_index, csr_data                  | in
//
// One word per cycle when not stalled (decode and negate; normalize, round,
// pack; select). Stages advance together whenever the output stage is empty
// or taken, so rsp_stall holds every stage and no word is lost or repeated.
// Synchronous reset clears the valid bits and the type registers.
`default_nettype none
module sample_type_to_float32_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_raw_value,
   input  wire logic        req_last_in,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_converted_value,
   output logic             rsp_last_out,
   output logic             rsp_bad_pairing,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [2:0]  csr_data
);
   import stfc_pkg::*;

   logic [2:0] in_type_ff;
   logic [1:0] out_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_type_ff  <= 3'd0;
         out_type_ff <= 2'd0;
      end else if (csr_write) begin
         if (csr_index == CSR_INPUT_TYPE) in_type_ff <= csr_data;
         else out_type_ff <= csr_data[1:0];
      end
   end

   logic advance;
   logic v1_ff, v2_ff, v3_ff;
   assign advance   = !v3_ff || !rsp_stall;
   assign req_stall = !advance;
   assign rsp_valid = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // ---------------- stage 1: decode pairing, integer magnitude
   s1_type s1_in, s1_ff;
   logic [63:0] d1_in, d1_ff;
   logic        same;
   logic [15:0] v16;
   logic [31:0] v32;

   always_comb begin
      same = (out_type_ff == OUT_SAME)
          || (out_type_ff == OUT_FLOAT32 && in_type_ff == IN_FLOAT32)
          || (out_type_ff == OUT_INT32 && in_type_ff == IN_INT32);
      v16 = req_raw_value[15:0];
      v32 = req_raw_value[31:0];
      s1_in          = '0;
      s1_in.last     = req_last_in;
      s1_in.op       = OP_BAD;
      d1_in          = req_raw_value;
      if (in_type_ff > IN_FLOAT64 || out_type_ff > OUT_INT32) begin
         s1_in.op = OP_BAD;
      end else if (same) begin
         s1_in.op = OP_PASS;
         unique case (in_type_ff)
            IN_UINT8:             s1_in.pass_val = {56'd0, req_raw_value[7:0]};
            IN_UINT16, IN_INT16:  s1_in.pass_val = {48'd0, v16};
            IN_INT32, IN_FLOAT32: s1_in.pass_val = {32'd0, v32};
            default:              s1_in.pass_val = req_raw_value;
         endcase
      end else if (out_type_ff == OUT_FLOAT32) begin
         unique case (in_type_ff)
            IN_UINT8: begin
               s1_in.op  = OP_CONV;
               s1_in.mag = {24'd0, req_raw_value[7:0]};
            end
            IN_INT16: begin
               s1_in.op  = OP_CONV;
               s1_in.neg = v16[15];
               s1_in.mag = {16'd0, v16[15] ? 16'(-v16) : v16};
               // -32768 negates to 0x8000 in 16 bits
               if (v16 == 16'h8000) s1_in.mag = 32'h8000;
            end
            IN_INT32: begin
               s1_in.op  = OP_CONV;
               s1_in.neg = v32[31];
               s1_in.mag = v32[31] ? (~v32 + 32'd1) : v32;
            end
            IN_FLOAT64: begin
               s1_in.op     = OP_CONV;
               s1_in.is_dbl = 1'b1;
            end
            default: s1_in.op = OP_BAD;
         endcase
      end else if (out_type_ff == OUT_INT32 && in_type_ff == IN_UINT16) begin
         s1_in.op       = OP_PASS;
         s1_in.pass_val = {48'd0, v16 & Uint16Mask};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         d1_ff <= d1_in;
      end
   end

   // ---------------- stage 2: normalize and round
   logic [31:0] res2_in, res2_ff;
   logic [1:0]  op2_in;
   logic        bad2_ff, last2_ff;
   logic [63:0] pass2_ff;

   logic [4:0]  p;
   logic [31:0] norm;
   logic [24:0] r_int;
   logic [7:0]  e_int;
   logic        g_i, st_i;
   logic        sgn;
   logic [10:0] de;
   logic [51:0] df;
   logic [52:0] dm;
   logic [11:0] ebias;
   logic [24:0] rd;
   logic [5:0]  sh;
   logic [53:0] shifted;
   logic [53:0] lost_mask;
   logic        rem_half, rem_above;
   logic [24:0] sub_r;
   logic [31:0] conv;

   always_comb begin
      // integer path: leading one position
      p = 5'd0;
      for (int i = 0; i < 32; i++) if (s1_ff.mag[i]) p = 5'(i);
      norm  = s1_ff.mag << (5'd31 - p);
      g_i   = norm[7];
      st_i  = |norm[6:0];
      r_int = {1'b0, norm[31:8]};
      if (g_i && (st_i || norm[8])) r_int = r_int + 25'd1;
      e_int = 8'(p) + 8'd127;
      if (r_int[24]) e_int = e_int + 8'd1;

      // double path
      sgn   = d1_ff[63];
      de    = d1_ff[62:52];
      df    = d1_ff[51:0];
      dm    = {1'b1, df};
      ebias = {1'b0, de} - 12'd896;
      rd    = {1'b0, dm[52:29]};
      if (dm[28] && ((|dm[27:0]) || dm[29])) rd = rd + 25'd1;
      sh = 6'd0;
      if (($signed(ebias) < 12'sd1) && ($signed(ebias) > -12'sd24))
         sh = 6'(12'd30 - ebias);
      shifted   = {1'b0, dm} >> sh;
      lost_mask = (54'd1 << sh) - 54'd1;
      rem_half  = ({1'b0, dm} & lost_mask) == (54'd1 << (sh - 6'd1));
      rem_above = ({1'b0, dm} & lost_mask) > (54'd1 << (sh - 6'd1));
      sub_r     = shifted[24:0];
      if (rem_above || (rem_half && shifted[0])) sub_r = sub_r + 25'd1;

      if (s1_ff.is_dbl) begin
         if (de == 11'h7FF) begin
            // NaN keeps fraction bits 50..29 under the quiet bit
            conv = (df == 52'd0) ? {sgn, 31'h7F800000}
                                 : {sgn, 8'hFF, 1'b1, df[50:29]};
         end else if (de == 11'd0) begin
            conv = {sgn, 31'd0};
         end else if ($signed(ebias) >= 12'sd255) begin
            conv = {sgn, 31'h7F800000};
         end else if ($signed(ebias) >= 12'sd1) begin
            if (rd[24] && ebias == 12'd254) conv = {sgn, 31'h7F800000};
            else if (rd[24]) conv = {sgn, 8'(ebias + 12'd1), 23'd0};
            else conv = {sgn, ebias[7:0], rd[22:0]};
         end else if ($signed(ebias) <= -12'sd24) begin
            conv = {sgn, 31'd0};
         end else begin
            conv = {sgn, 6'd0, sub_r};
         end
      end else if (s1_ff.mag == 32'd0) begin
         conv = 32'd0;
      end else begin
         conv = {s1_ff.neg, e_int, r_int[24] ? 23'd0 : r_int[22:0]};
      end
      res2_in = conv;
      op2_in  = {s1_ff.op == OP_BAD, s1_ff.op == OP_PASS};
   end

   logic pass2_sel_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         res2_ff      <= res2_in;
         bad2_ff      <= op2_in[1];
         pass2_sel_ff <= op2_in[0];
         last2_ff     <= s1_ff.last;
         pass2_ff     <= s1_ff.pass_val;
      end
   end

   // ---------------- stage 3: select and register the output word
   logic [63:0] val3_in, val3_ff;
   logic        bad3_ff, last3_ff;

   always_comb begin
      priority if (bad2_ff) val3_in = 64'd0;
      else if (pass2_sel_ff) val3_in = pass2_ff;
      else val3_in = {32'd0, res2_ff};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         val3_ff  <= val3_in;
         bad3_ff  <= bad2_ff;
         last3_ff <= last2_ff;
      end
   end

   assign rsp_converted_value = val3_ff;
   assign rsp_last_out        = last3_ff;
   assign rsp_bad_pairing     = bad3_ff;

   // ---------------- checks
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_pairing |-> rsp_converted_value == 64'd0)
      else $error("bad pairing word carries data");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_converted_value))
      else $error("stalled word changed");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall && v2_ff |=> rsp_valid)
      else $error("pipeline dropped a word");
endmodule
`default_nettype wire

>>> test/stfc_checker.sv
// Checker: tracks the type registers, predicts each converted word and compares
`timescale 1ns / 100ps
module stfc_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [63:0] req_raw_value,
   input  logic        req_last_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [63:0] rsp_converted_value,
   input  logic        rsp_last_out,
   input  logic        rsp_bad_pairing,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [2:0]  csr_data,
   output int          fail_count,
   output int          pending
);
   import stfc_pkg::*;

   typedef struct {
      logic [63:0] value;
      logic        last;
      logic        bad;
   } conv_word_type;

   logic [2:0]     src_type;
   logic [1:0]     dst_type;
   conv_word_type  awaited_words[$];

   // right shift with round to nearest, ties to even; sh in 1..63
   function automatic logic [63:0] round_shift(logic [63:0] m, int sh);
      logic [63:0] q, rem, half;
      q    = m >> sh;
      rem  = m & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0]))
         q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [31:0] int_to_f32(logic neg, logic [63:0] mag);
      int          msb;
      logic [63:0] mant;
      msb = 0;
      if (mag == 64'd0)
         return 32'd0;
      for (int i = 0; i < 64; i++)
         if (mag[i])
            msb = i;
      if (msb <= 23) begin
         mant = mag << (23 - msb);
      end else begin
         mant = round_shift(mag, msb - 23);
         if (mant == (64'd1 << 24)) begin
            mant = mant >> 1;
            msb++;
         end
      end
      return {neg, 8'(msb + 127), mant[22:0]};
   endfunction

   function automatic logic [31:0] dbl_to_f32(logic [63:0] d);
      logic        sgn;
      logic [10:0] ex;
      logic [51:0] frac;
      logic [63:0] mant, r;
      int          ebias, sh;
      sgn  = d[63];
      ex   = d[62:52];
      frac = d[51:0];
      if (ex == 11'h7FF) begin
         if (frac == 52'd0)
            return {sgn, 8'hFF, 23'd0};
         return {sgn, 9'h1FF, frac[50:29]};
      end
      if (ex == 11'd0)
         return {sgn, 31'd0};
      mant  = {11'd1, frac};
      ebias = int'(ex) - 896;
      if (ebias >= 255)
         return {sgn, 8'hFF, 23'd0};
      if (ebias >= 1) begin
         r = round_shift(mant, 29);
         if (r == (64'd1 << 24)) begin
            r = r >> 1;
            ebias++;
         end
         if (ebias >= 255)
            return {sgn, 8'hFF, 23'd0};
         return {sgn, 8'(ebias), r[22:0]};
      end
      sh = 30 - ebias;
      if (sh >= 54)
         return {sgn, 31'd0};
      r = round_shift(mant, sh);
      return {sgn, r[30:0]};
   endfunction

   function automatic conv_word_type convert_word(logic [63:0] raw, logic last);
      conv_word_type w;
      logic          same;
      w.value = 64'd0;
      w.last  = last;
      w.bad   = 1'b0;
      same = (dst_type == OUT_SAME) || (dst_type == OUT_FLOAT32 && src_type == IN_FLOAT32)
             || (dst_type == OUT_INT32 && src_type == IN_INT32);
      if (src_type > IN_FLOAT64 || dst_type > OUT_INT32) begin
         w.bad = 1'b1;
      end else if (same) begin
         case (src_type)
            IN_UINT8:             w.value = {56'd0, raw[7:0]};
            IN_UINT16, IN_INT16:  w.value = {48'd0, raw[15:0]};
            IN_INT32, IN_FLOAT32: w.value = {32'd0, raw[31:0]};
            default:              w.value = raw;
         endcase
      end else if (dst_type == OUT_FLOAT32) begin
         case (src_type)
            IN_UINT8:   w.value = {32'd0, int_to_f32(1'b0, {56'd0, raw[7:0]})};
            IN_INT16:   w.value = {32'd0, int_to_f32(raw[15],
                           raw[15] ? 64'(17'h10000 - raw[15:0]) : {48'd0, raw[15:0]})};
            IN_INT32:   w.value = {32'd0, int_to_f32(raw[31],
                           raw[31] ? 64'(33'h100000000 - raw[31:0]) : {32'd0, raw[31:0]})};
            IN_FLOAT64: w.value = {32'd0, dbl_to_f32(raw)};
            default:    w.bad = 1'b1;
         endcase
      end else if (dst_type == OUT_INT32 && src_type == IN_UINT16) begin
         w.value = {48'd0, raw[15:0] & Uint16Mask};
      end else begin
         w.bad = 1'b1;
      end
      if (w.bad)
         w.value = 64'd0;
      return w;
   endfunction

   assign pending = awaited_words.size();

   always @(posedge clock) begin
      conv_word_type want;
      int            errs;
      errs = 0;
      if (reset) begin
         src_type   <= IN_UINT8;
         dst_type   <= OUT_SAME;
         fail_count <= 0;
         awaited_words.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_INPUT_TYPE)
               src_type <= csr_data;
            else
               dst_type <= csr_data[1:0];
         end
         if (req_valid && !req_stall)
            awaited_words.push_back(convert_word(req_raw_value, req_last_in));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_words.size() == 0) begin
               $error("unexpected word out: value %h", rsp_converted_value);
               errs++;
            end else begin
               want = awaited_words.pop_front();
               if (rsp_converted_value !== want.value) begin
                  $error("converted_value: expected %h, got %h", want.value,
                         rsp_converted_value);
                  errs++;
               end
               if (rsp_last_out !== want.last) begin
                  $error("last_out: expected %b, got %b", want.last, rsp_last_out);
                  errs++;
               end
               if (rsp_bad_pairing !== want.bad) begin
                  $error("bad_pairing: expected %b, got %b", want.bad, rsp_bad_pairing);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

>>> test/tb_sample_type_to_float32_converter.sv
// Testbench top: clock, reset, stimulus, receiver back-pressure and verdict
`timescale 1ns / 100ps
module tb_sample_type_to_float32_converter;
   import stfc_pkg::*;

   localparam int IdleLimit     = 3000;
   localparam int WordsPerSetup = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_raw_value = 64'd0;
   logic        req_last_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_converted_value;
   logic        rsp_last_out;
   logic        rsp_bad_pairing;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [2:0]  csr_data = 3'd0;
   int          fail_count, pending;
   int          cycle_count = 0;
   int          idle_cycles = 0;
   int          words_sent = 0;
   int          setups_run = 0;
   bit          sender_quiet = 1'b0;

   logic [63:0] dbl_cases[14] = '{
      64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001,
      64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
      64'hFFF0_0000_0000_0001, 64'h47EF_FFFF_F000_0000, 64'h47F0_0000_0000_0000,
      64'h3810_0000_0000_0000, 64'h36A0_0000_0000_0000, 64'h3690_0000_0000_0000,
      64'h3FF0_0000_1000_0000, 64'h3FF0_0000_3000_0000};

   always #5 clock = ~clock;

   sample_type_to_float32_converter u_top (.*);
   stfc_checker u_checker (.*);

   // watchdog: cycles with no word moving on either side
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // receiver: random stalls, two long hold-offs, one quiet window
   int hold_left = 0;
   always @(negedge clock) begin
      if (cycle_count == 1000 || cycle_count == 1400)
         hold_left = 80;
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (cycle_count > 200 && cycle_count < 600) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 7);
      end
   end

   task automatic send_word(logic [63:0] raw, logic last);
      while (!sender_quiet && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_raw_value <= raw;
      req_last_in   <= last;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   // drains the pipe, then writes both type registers
   task automatic set_types(logic [2:0] src, logic [2:0] dst);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_INPUT_TYPE;
      csr_data  <= src;
      @(negedge clock);
      csr_index <= CSR_OUTPUT_TYPE;
      csr_data  <= dst;
      @(negedge clock);
      csr_write <= 1'b0;
      setups_run++;
   endtask

   function automatic logic [63:0] pick_raw(logic [2:0] src);
      logic [63:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: r = r >> $urandom_range(8, 63);
         1: r = $urandom_range(0, 1) ? 64'd0 : '1;
         2: if (src == IN_FLOAT64)
               r[62:52] = 11'($urandom_range(840, 1170));
         3: if (src == IN_FLOAT64)
               r[62:52] = $urandom_range(0, 1) ? 11'h7FF : 11'd0;
         default: ;
      endcase
      return r;
   endfunction

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: double specials and rounding edges, integer extremes
      set_types(IN_FLOAT64, OUT_FLOAT32);
      foreach (dbl_cases[i])
         send_word(dbl_cases[i], i[0]);
      set_types(IN_INT32, OUT_FLOAT32);
      send_word(64'hFFFF_FFFF_8000_0000, 1'b1);
      send_word(64'h7FFF_FFFF, 1'b0);
      send_word(64'hFFFF_FFFF, 1'b0);
      send_word(64'h0100_0001, 1'b0);
      send_word(64'h0, 1'b1);
      set_types(IN_INT16, OUT_FLOAT32);
      send_word(64'h8000, 1'b0);
      send_word(64'h7FFF, 1'b1);
      set_types(IN_UINT8, OUT_FLOAT32);
      send_word(64'hFF, 1'b0);

      // random: every register value, unused codes included
      for (int s = 0; s < 8; s++) begin
         for (int d = 0; d < 4; d++) begin
            set_types(3'(s), 3'(d));
            for (int n = 0; n < WordsPerSetup; n++) begin
               sender_quiet = (words_sent > 500 && words_sent < 700);
               send_word(pick_raw(3'(s)), $urandom_range(0, 7) == 0);
            end
         end
      end
      req_valid <= 1'b0;

      while (pending != 0)
         @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Covered %0d words over %0d type settings, all pairings incl. bad codes.",
               words_sent, setups_run);
      if (fail_count == 0 && pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
